FILE: rtl/phase_field_cell_update_defines.svh
// Assertion macros shared by the phase field cell update checker.
// No dependencies; take it in with a plain include.
`ifndef PHASE_FIELD_CELL_UPDATE_DEFINES_SVH
`define PHASE_FIELD_CELL_UPDATE_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define PFCU_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfcu: implication failed");

// Next-cycle implication, off while reset is high
`define PFCU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfcu: next-cycle implication failed");

// Implication after a fixed number of cycles, off while reset is high
`define PFCU_ASSERT_DELAY(label, clk, rst, ante, cons, dly) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("pfcu: delayed implication failed");

`endif

FILE: rtl/pfcu_pkg.sv
// Shared types and constants of the phase field cell update block.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package pfcu_pkg;

   // Field and register widths
   localparam int VALUE_W    = 16;
   localparam int COEF_W     = 18;
   localparam int NUM_REGS   = 6;
   localparam int OTHER_FIELDS = 3;

   // APB port geometry: registers on 4-byte steps
   localparam int APB_DATA_W = 32;
   localparam int ADDR_W     = 5;
   localparam int IDX_W      = 3;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic [IDX_W-1:0]          reg_idx_type;

   // Register indexes
   localparam reg_idx_type REG_BULK    = 3'd0;
   localparam reg_idx_type REG_BARRIER = 3'd1;
   localparam reg_idx_type REG_CROSS   = 3'd2;
   localparam reg_idx_type REG_GRAD_X  = 3'd3;
   localparam reg_idx_type REG_GRAD_Y  = 3'd4;
   localparam reg_idx_type REG_GRAD_Z  = 3'd5;

   localparam coef_type COEF_RESET [NUM_REGS] = '{
      -18'sd3518, 18'sd5745, 18'sd7340, 18'sd4748, 18'sd4748, 18'sd4748
   };

   // Output clipping limits
   localparam value_type VALUE_MAX = 16'sh7fff;
   localparam value_type VALUE_MIN = 16'sh8000;

endpackage

`default_nettype wire

FILE: rtl/phase_field_cell_update.sv
// An item taken with start passes the stage registers s1 to s7 and then the output
// register; rsp_valid is registered there and marks the result.
// Throughput: one item per clock; busy never rises and the receiver cannot stall.
// Eight register stages, each with at most one multiplier level or one wide add.
// Synchronous reset drops items in flight and reloads the coefficient registers.
`timescale 1ns / 1ps
`default_nettype none

// Top level: explicit Allen-Cahn update of one cell, APB coefficient registers.
// Depends on pfcu_pkg.
module phase_field_cell_update #(
   parameter int GRAINS          = 4,
   parameter int VALUE_FRAC_BITS = 13,
   parameter int COEF_FRAC_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               start,
   output logic                               busy,
   input  pfcu_pkg::value_type                req_center,
   input  pfcu_pkg::value_type                req_x_minus,
   input  pfcu_pkg::value_type                req_x_plus,
   input  pfcu_pkg::value_type                req_y_minus,
   input  pfcu_pkg::value_type                req_y_plus,
   input  pfcu_pkg::value_type                req_z_minus,
   input  pfcu_pkg::value_type                req_z_plus,
   input  pfcu_pkg::value_type                req_other_grain_a,
   input  pfcu_pkg::value_type                req_other_grain_b,
   input  pfcu_pkg::value_type                req_other_grain_c,
   // result channel
   output logic                               rsp_valid,
   output pfcu_pkg::value_type                rsp_new_value,
   output logic                               rsp_saturated,
   // APB configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pfcu_pkg::ADDR_W-1:0]        paddr,
   input  logic [pfcu_pkg::APB_DATA_W-1:0]    pwdata,
   output logic [pfcu_pkg::APB_DATA_W-1:0]    prdata,
   output logic                               pready
);

   localparam int F  = VALUE_FRAC_BITS;
   localparam int C  = COEF_FRAC_BITS;
   localparam int VW = pfcu_pkg::VALUE_W;
   localparam int KW = pfcu_pkg::COEF_W;

   localparam int ONE_F  = 1 << F;
   localparam int HALF_F = 1 << (F - 1);
   localparam int HALF_C = 1 << (C - 1);

   // other grains that take part in the cross term
   localparam int OTHER_USED = (GRAINS - 1 > pfcu_pkg::OTHER_FIELDS) ?
                               pfcu_pkg::OTHER_FIELDS : GRAINS - 1;

   // Intermediate widths, all exact for the full input range
   localparam int V_W   = ((VW > F + 1) ? VW : F + 1) + 2;  // one - c
   localparam int W_W   = V_W + 1;                           // one - 2c
   localparam int CV_W  = VW + V_W;                          // c*v
   localparam int P_W   = CV_W + 1 - F;                      // p
   localparam int SQ_W  = 2 * VW;                            // one square
   localparam int SS_W  = SQ_W + 3;                          // sum of squares
   localparam int S_W   = SS_W - F;                          // S
   localparam int PP_W  = 2 * P_W;                           // p*p
   localparam int B_W   = PP_W + 1 - F;                      // B
   localparam int PW_W  = P_W + W_W;                         // p*w
   localparam int D_W   = PW_W + 1 - F;                      // D
   localparam int CS_W  = VW + S_W;                          // c*S
   localparam int X_W   = CS_W + 1 - F;                      // X
   localparam int L_W   = VW + 2;                            // Laplacian term
   localparam int TB_W  = KW + B_W;
   localparam int TD_W  = KW + D_W;
   localparam int TX_W  = KW + X_W;
   localparam int TL_W  = KW + L_W;
   localparam int TC_W  = VW + C + 1;
   localparam int M1_W  = (TB_W > TD_W) ? TB_W : TD_W;
   localparam int M2_W  = (M1_W > TX_W) ? M1_W : TX_W;
   localparam int M3_W  = (M2_W > TL_W) ? M2_W : TL_W;
   localparam int M4_W  = (M3_W > TC_W) ? M3_W : TC_W;
   localparam int ACC_W = M4_W + 3;
   localparam int R_W   = ACC_W - C;

   // ------------------------------------------------------------------
   // Coefficient registers
   // ------------------------------------------------------------------
   pfcu_pkg::coef_type    coef_ff [pfcu_pkg::NUM_REGS];
   pfcu_pkg::coef_type    coef_in [pfcu_pkg::NUM_REGS];
   logic                  cfg_wr;
   pfcu_pkg::reg_idx_type cfg_idx;

   assign cfg_wr  = psel & penable & pwrite & pready;
   assign cfg_idx = paddr[pfcu_pkg::ADDR_W-1:2];
   assign pready  = 1'b1;

   always_comb begin
      for (int i = 0; i < pfcu_pkg::NUM_REGS; i++) begin
         coef_in[i] = coef_ff[i];
         if (cfg_wr && cfg_idx == pfcu_pkg::IDX_W'(i)) begin
            coef_in[i] = pwdata[KW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= pfcu_pkg::COEF_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // read back, sign extended; unmapped addresses read zero
   always_comb begin
      prdata = '0;
      if (cfg_idx < pfcu_pkg::IDX_W'(pfcu_pkg::NUM_REGS)) begin
         prdata = pfcu_pkg::APB_DATA_W'(coef_ff[cfg_idx]);
      end
   end

   // the pipeline never holds off an item
   assign busy = 1'b0;

   // ------------------------------------------------------------------
   // Stage 1: c*v, squares of the other grains, Laplacian sums
   // ------------------------------------------------------------------
   logic                    s1_valid_ff, s1_valid_in;
   logic signed [VW-1:0]    s1_c_ff, s1_c_in;
   logic signed [W_W-1:0]   s1_w_ff, s1_w_in;
   logic signed [CV_W-1:0]  s1_cv_ff, s1_cv_in;
   logic signed [SQ_W-1:0]  s1_sqa_ff, s1_sqa_in;
   logic signed [SQ_W-1:0]  s1_sqb_ff, s1_sqb_in;
   logic signed [SQ_W-1:0]  s1_sqc_ff, s1_sqc_in;
   logic signed [L_W-1:0]   s1_lx_ff, s1_lx_in;
   logic signed [L_W-1:0]   s1_ly_ff, s1_ly_in;
   logic signed [L_W-1:0]   s1_lz_ff, s1_lz_in;
   logic signed [V_W-1:0]   s1_v;

   always_comb begin
      s1_valid_in = start & ~busy;
      s1_c_in     = req_center;
      s1_v        = V_W'(ONE_F) - V_W'(req_center);
      s1_w_in     = W_W'(ONE_F) - (W_W'(req_center) <<< 1);
      s1_cv_in    = CV_W'(req_center) * CV_W'(s1_v);
      // grains beyond the configured count contribute nothing
      s1_sqa_in   = (OTHER_USED > 0) ?
                    SQ_W'(req_other_grain_a) * SQ_W'(req_other_grain_a) : '0;
      s1_sqb_in   = (OTHER_USED > 1) ?
                    SQ_W'(req_other_grain_b) * SQ_W'(req_other_grain_b) : '0;
      s1_sqc_in   = (OTHER_USED > 2) ?
                    SQ_W'(req_other_grain_c) * SQ_W'(req_other_grain_c) : '0;
      s1_lx_in    = L_W'(req_x_minus) + L_W'(req_x_plus) - (L_W'(req_center) <<< 1);
      s1_ly_in    = L_W'(req_y_minus) + L_W'(req_y_plus) - (L_W'(req_center) <<< 1);
      s1_lz_in    = L_W'(req_z_minus) + L_W'(req_z_plus) - (L_W'(req_center) <<< 1);
   end

   // ------------------------------------------------------------------
   // Stage 2: p = round(c*v), S = round(sum of squares)
   // ------------------------------------------------------------------
   logic                    s2_valid_ff, s2_valid_in;
   logic signed [VW-1:0]    s2_c_ff, s2_c_in;
   logic signed [W_W-1:0]   s2_w_ff, s2_w_in;
   logic signed [P_W-1:0]   s2_p_ff, s2_p_in;
   logic signed [S_W-1:0]   s2_s_ff, s2_s_in;
   logic signed [L_W-1:0]   s2_lx_ff, s2_lx_in;
   logic signed [L_W-1:0]   s2_ly_ff, s2_ly_in;
   logic signed [L_W-1:0]   s2_lz_ff, s2_lz_in;
   logic signed [CV_W:0]    s2_cv_rnd;
   logic signed [SS_W-1:0]  s2_ss_rnd;

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_c_in     = s1_c_ff;
      s2_w_in     = s1_w_ff;
      s2_cv_rnd   = (CV_W + 1)'(s1_cv_ff) + (CV_W + 1)'(HALF_F);
      s2_p_in     = s2_cv_rnd[CV_W:F];
      s2_ss_rnd   = SS_W'(s1_sqa_ff) + SS_W'(s1_sqb_ff) + SS_W'(s1_sqc_ff)
                  + SS_W'(HALF_F);
      s2_s_in     = s2_ss_rnd[SS_W-1:F];
      s2_lx_in    = s1_lx_ff;
      s2_ly_in    = s1_ly_ff;
      s2_lz_in    = s1_lz_ff;
   end

   // ------------------------------------------------------------------
   // Stage 3: p*p, p*w, c*S
   // ------------------------------------------------------------------
   logic                    s3_valid_ff, s3_valid_in;
   logic signed [VW-1:0]    s3_c_ff, s3_c_in;
   logic signed [PP_W-1:0]  s3_pp_ff, s3_pp_in;
   logic signed [PW_W-1:0]  s3_pw_ff, s3_pw_in;
   logic signed [CS_W-1:0]  s3_cs_ff, s3_cs_in;
   logic signed [L_W-1:0]   s3_lx_ff, s3_lx_in;
   logic signed [L_W-1:0]   s3_ly_ff, s3_ly_in;
   logic signed [L_W-1:0]   s3_lz_ff, s3_lz_in;

   always_comb begin
      s3_valid_in = s2_valid_ff;
      s3_c_in     = s2_c_ff;
      s3_pp_in    = PP_W'(s2_p_ff) * PP_W'(s2_p_ff);
      s3_pw_in    = PW_W'(s2_p_ff) * PW_W'(s2_w_ff);
      s3_cs_in    = CS_W'(s2_c_ff) * CS_W'(s2_s_ff);
      s3_lx_in    = s2_lx_ff;
      s3_ly_in    = s2_ly_ff;
      s3_lz_in    = s2_lz_ff;
   end

   // ------------------------------------------------------------------
   // Stage 4: round B, D, X
   // ------------------------------------------------------------------
   logic                    s4_valid_ff, s4_valid_in;
   logic signed [VW-1:0]    s4_c_ff, s4_c_in;
   logic signed [B_W-1:0]   s4_b_ff, s4_b_in;
   logic signed [D_W-1:0]   s4_d_ff, s4_d_in;
   logic signed [X_W-1:0]   s4_x_ff, s4_x_in;
   logic signed [L_W-1:0]   s4_lx_ff, s4_lx_in;
   logic signed [L_W-1:0]   s4_ly_ff, s4_ly_in;
   logic signed [L_W-1:0]   s4_lz_ff, s4_lz_in;
   logic signed [PP_W:0]    s4_pp_rnd;
   logic signed [PW_W:0]    s4_pw_rnd;
   logic signed [CS_W:0]    s4_cs_rnd;

   always_comb begin
      s4_valid_in = s3_valid_ff;
      s4_c_in     = s3_c_ff;
      s4_pp_rnd   = (PP_W + 1)'(s3_pp_ff) + (PP_W + 1)'(HALF_F);
      s4_pw_rnd   = (PW_W + 1)'(s3_pw_ff) + (PW_W + 1)'(HALF_F);
      s4_cs_rnd   = (CS_W + 1)'(s3_cs_ff) + (CS_W + 1)'(HALF_F);
      s4_b_in     = s4_pp_rnd[PP_W:F];
      s4_d_in     = s4_pw_rnd[PW_W:F];
      s4_x_in     = s4_cs_rnd[CS_W:F];
      s4_lx_in    = s3_lx_ff;
      s4_ly_in    = s3_ly_ff;
      s4_lz_in    = s3_lz_ff;
   end

   // ------------------------------------------------------------------
   // Stage 5: coefficient products
   // ------------------------------------------------------------------
   logic                    s5_valid_ff, s5_valid_in;
   logic signed [VW-1:0]    s5_c_ff, s5_c_in;
   logic signed [TB_W-1:0]  s5_tb_ff, s5_tb_in;
   logic signed [TD_W-1:0]  s5_td_ff, s5_td_in;
   logic signed [TX_W-1:0]  s5_tx_ff, s5_tx_in;
   logic signed [TL_W-1:0]  s5_tlx_ff, s5_tlx_in;
   logic signed [TL_W-1:0]  s5_tly_ff, s5_tly_in;
   logic signed [TL_W-1:0]  s5_tlz_ff, s5_tlz_in;

   always_comb begin
      s5_valid_in = s4_valid_ff;
      s5_c_in     = s4_c_ff;
      s5_tb_in    = TB_W'(coef_ff[pfcu_pkg::REG_BULK]) * TB_W'(s4_b_ff);
      s5_td_in    = TD_W'(coef_ff[pfcu_pkg::REG_BARRIER]) * TD_W'(s4_d_ff);
      s5_tx_in    = TX_W'(coef_ff[pfcu_pkg::REG_CROSS]) * TX_W'(s4_x_ff);
      s5_tlx_in   = TL_W'(coef_ff[pfcu_pkg::REG_GRAD_X]) * TL_W'(s4_lx_ff);
      s5_tly_in   = TL_W'(coef_ff[pfcu_pkg::REG_GRAD_Y]) * TL_W'(s4_ly_ff);
      s5_tlz_in   = TL_W'(coef_ff[pfcu_pkg::REG_GRAD_Z]) * TL_W'(s4_lz_ff);
   end

   // ------------------------------------------------------------------
   // Stage 6: two partial sums of the accumulator
   // ------------------------------------------------------------------
   logic                    s6_valid_ff, s6_valid_in;
   logic signed [ACC_W-1:0] s6_sa_ff, s6_sa_in;
   logic signed [ACC_W-1:0] s6_sb_ff, s6_sb_in;

   always_comb begin
      s6_valid_in = s5_valid_ff;
      s6_sa_in    = (ACC_W'(s5_c_ff) <<< C) - ACC_W'(s5_tb_ff) - ACC_W'(s5_td_ff);
      s6_sb_in    = ACC_W'(s5_tlx_ff) + ACC_W'(s5_tly_ff) + ACC_W'(s5_tlz_ff)
                  - ACC_W'(s5_tx_ff);
   end

   // ------------------------------------------------------------------
   // Stage 7: final sum with rounding half
   // ------------------------------------------------------------------
   logic                    s7_valid_ff, s7_valid_in;
   logic signed [ACC_W-1:0] s7_acc_ff, s7_acc_in;

   always_comb begin
      s7_valid_in = s6_valid_ff;
      s7_acc_in   = s6_sa_ff + s6_sb_ff + ACC_W'(HALF_C);
   end

   // ------------------------------------------------------------------
   // Stage 8: scale down, clip, output register
   // ------------------------------------------------------------------
   logic                    rsp_valid_ff, rsp_valid_in;
   pfcu_pkg::value_type     rsp_value_ff, rsp_value_in;
   logic                    rsp_sat_ff, rsp_sat_in;
   logic signed [R_W-1:0]   s8_res;

   always_comb begin
      rsp_valid_in = s7_valid_ff;
      s8_res       = s7_acc_ff[ACC_W-1:C];
      rsp_value_in = s8_res[VW-1:0];
      rsp_sat_in   = 1'b0;
      if (s8_res > R_W'(pfcu_pkg::VALUE_MAX)) begin
         rsp_value_in = pfcu_pkg::VALUE_MAX;
         rsp_sat_in   = 1'b1;
      end else if (s8_res < R_W'(pfcu_pkg::VALUE_MIN)) begin
         rsp_value_in = pfcu_pkg::VALUE_MIN;
         rsp_sat_in   = 1'b1;
      end
   end

   // valid bits: cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         s5_valid_ff  <= s5_valid_in;
         s6_valid_ff  <= s6_valid_in;
         s7_valid_ff  <= s7_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: free-running, qualified by the valid bits
   always_ff @(posedge clock) begin
      s1_c_ff      <= s1_c_in;
      s1_w_ff      <= s1_w_in;
      s1_cv_ff     <= s1_cv_in;
      s1_sqa_ff    <= s1_sqa_in;
      s1_sqb_ff    <= s1_sqb_in;
      s1_sqc_ff    <= s1_sqc_in;
      s1_lx_ff     <= s1_lx_in;
      s1_ly_ff     <= s1_ly_in;
      s1_lz_ff     <= s1_lz_in;
      s2_c_ff      <= s2_c_in;
      s2_w_ff      <= s2_w_in;
      s2_p_ff      <= s2_p_in;
      s2_s_ff      <= s2_s_in;
      s2_lx_ff     <= s2_lx_in;
      s2_ly_ff     <= s2_ly_in;
      s2_lz_ff     <= s2_lz_in;
      s3_c_ff      <= s3_c_in;
      s3_pp_ff     <= s3_pp_in;
      s3_pw_ff     <= s3_pw_in;
      s3_cs_ff     <= s3_cs_in;
      s3_lx_ff     <= s3_lx_in;
      s3_ly_ff     <= s3_ly_in;
      s3_lz_ff     <= s3_lz_in;
      s4_c_ff      <= s4_c_in;
      s4_b_ff      <= s4_b_in;
      s4_d_ff      <= s4_d_in;
      s4_x_ff      <= s4_x_in;
      s4_lx_ff     <= s4_lx_in;
      s4_ly_ff     <= s4_ly_in;
      s4_lz_ff     <= s4_lz_in;
      s5_c_ff      <= s5_c_in;
      s5_tb_ff     <= s5_tb_in;
      s5_td_ff     <= s5_td_in;
      s5_tx_ff     <= s5_tx_in;
      s5_tlx_ff    <= s5_tlx_in;
      s5_tly_ff    <= s5_tly_in;
      s5_tlz_ff    <= s5_tlz_in;
      s6_sa_ff     <= s6_sa_in;
      s6_sb_ff     <= s6_sb_in;
      s7_acc_ff    <= s7_acc_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_value = rsp_value_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

`default_nettype wire

FILE: rtl/pfcu_checker.sv
// Port-level checker for phase_field_cell_update, attached by bind.
// Depends on pfcu_pkg and phase_field_cell_update_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "phase_field_cell_update_defines.svh"

module pfcu_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input pfcu_pkg::value_type              rsp_new_value,
   input logic                             rsp_saturated,
   input logic                             psel,
   input logic                             penable,
   input logic                             pwrite,
   input logic [pfcu_pkg::ADDR_W-1:0]      paddr,
   input logic [pfcu_pkg::APB_DATA_W-1:0]  pwdata,
   input logic [pfcu_pkg::APB_DATA_W-1:0]  prdata,
   input logic                             pready
);

   logic                  item_taken;
   logic                  cfg_write;
   logic                  at_limit;
   pfcu_pkg::reg_idx_type wr_idx;

   assign item_taken = start & ~busy;
   assign wr_idx     = paddr[pfcu_pkg::ADDR_W-1:2];
   assign cfg_write  = psel & penable & pwrite & pready
                     & (wr_idx < pfcu_pkg::IDX_W'(pfcu_pkg::NUM_REGS));
   assign at_limit   = (rsp_new_value == pfcu_pkg::VALUE_MAX)
                     || (rsp_new_value == pfcu_pkg::VALUE_MIN);

   // every item taken comes out of the pipeline, and nothing else does
   `PFCU_ASSERT_DELAY(a_item_comes_out, clock, reset, item_taken, rsp_valid, 8)
   `PFCU_ASSERT_IMPLIES(a_result_has_item, clock, reset, rsp_valid, $past(item_taken, 8))

   // a clipped result sits on one of the two limits
   `PFCU_ASSERT_IMPLIES(a_sat_on_limit, clock, reset, rsp_valid && rsp_saturated, at_limit)

   // a written coefficient reads back at the same address
   `PFCU_ASSERT_NEXT(a_cfg_readback, clock, reset, cfg_write, (paddr != $past(paddr)) || (prdata[pfcu_pkg::COEF_W-1:0] == $past(pwdata[pfcu_pkg::COEF_W-1:0])))

endmodule

bind phase_field_cell_update pfcu_checker u_pfcu_checker (.*);

`default_nettype wire

FILE: tb/phase_field_cell_update_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for phase_field_cell_update: predicts each cell update
// in fixed point, drives items and APB coefficient writes. Depends on pfcu_pkg.

module phase_field_cell_update_tb;

   localparam int GRAINS          = 4;
   localparam int VALUE_FRAC_BITS = 13;
   localparam int COEF_FRAC_BITS  = 16;
   localparam int GRAIN_FIELDS    = (GRAINS - 1 < pfcu_pkg::OTHER_FIELDS) ?
                                    GRAINS - 1 : pfcu_pkg::OTHER_FIELDS;
   localparam int RANDOM_PER_PHASE = 84;
   localparam int LAST_PHASE       = 5;

   typedef struct {
      pfcu_pkg::value_type center, x_minus, x_plus, y_minus, y_plus, z_minus, z_plus;
      pfcu_pkg::value_type grain_a, grain_b, grain_c;
   } cell_type;

   typedef struct {
      pfcu_pkg::value_type new_value;
      logic                saturated;
   } cell_result_type;

   // DUT connections, all inputs known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   pfcu_pkg::value_type req_center = '0, req_x_minus = '0, req_x_plus = '0;
   pfcu_pkg::value_type req_y_minus = '0, req_y_plus = '0, req_z_minus = '0;
   pfcu_pkg::value_type req_z_plus = '0;
   pfcu_pkg::value_type req_other_grain_a = '0, req_other_grain_b = '0;
   pfcu_pkg::value_type req_other_grain_c = '0;
   logic rsp_valid;
   pfcu_pkg::value_type rsp_new_value;
   logic rsp_saturated;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [pfcu_pkg::ADDR_W-1:0] paddr = '0;
   logic [pfcu_pkg::APB_DATA_W-1:0] pwdata = '0;
   logic [pfcu_pkg::APB_DATA_W-1:0] prdata;
   logic pready;

   // Testbench state
   pfcu_pkg::coef_type coef_shadow [pfcu_pkg::NUM_REGS] = '{-18'sd3518, 18'sd5745,
                                        18'sd7340, 18'sd4748, 18'sd4748, 18'sd4748};
   cell_type        cell_queue [$];
   cell_result_type expected_updates [$];
   cell_type        cell_on_bus;
   cell_result_type next_update;
   int  cells_sent = 0;
   int  cells_taken = 0;
   int  mismatch_count = 0;
   int  idle_pct = 0;
   int  quiet_run = 0;
   bit  hold_off;

   phase_field_cell_update #(
      .GRAINS(GRAINS),
      .VALUE_FRAC_BITS(VALUE_FRAC_BITS),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_center(req_center),
      .req_x_minus(req_x_minus), .req_x_plus(req_x_plus),
      .req_y_minus(req_y_minus), .req_y_plus(req_y_plus),
      .req_z_minus(req_z_minus), .req_z_plus(req_z_plus),
      .req_other_grain_a(req_other_grain_a),
      .req_other_grain_b(req_other_grain_b),
      .req_other_grain_c(req_other_grain_c),
      .rsp_valid(rsp_valid), .rsp_new_value(rsp_new_value), .rsp_saturated(rsp_saturated),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Round half up, then floor shift
   function automatic longint round_shift(longint x, int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   // One explicit Euler step of the order parameter, using the shadow coefficients
   function automatic cell_result_type predict_update(cell_type site);
      cell_result_type r;
      pfcu_pkg::value_type others [pfcu_pkg::OTHER_FIELDS];
      longint c, one, v, w, p, bulk_term, well_term, sum_sq, cross_term;
      longint lap_x, lap_y, lap_z, acc, res;
      others = '{site.grain_a, site.grain_b, site.grain_c};
      c   = site.center;
      one = longint'(1) <<< VALUE_FRAC_BITS;
      v   = one - c;
      w   = one - 2 * c;
      p          = round_shift(c * v, VALUE_FRAC_BITS);
      bulk_term  = round_shift(p * p, VALUE_FRAC_BITS);
      well_term  = round_shift(p * w, VALUE_FRAC_BITS);
      sum_sq = 0;
      for (int k = 0; k < GRAIN_FIELDS; k++) begin
         sum_sq += longint'(others[k]) * longint'(others[k]);
      end
      sum_sq     = round_shift(sum_sq, VALUE_FRAC_BITS);
      cross_term = round_shift(c * sum_sq, VALUE_FRAC_BITS);
      lap_x = longint'(site.x_minus) + longint'(site.x_plus) - 2 * c;
      lap_y = longint'(site.y_minus) + longint'(site.y_plus) - 2 * c;
      lap_z = longint'(site.z_minus) + longint'(site.z_plus) - 2 * c;
      acc = c <<< COEF_FRAC_BITS;
      acc -= longint'(coef_shadow[pfcu_pkg::REG_BULK]) * bulk_term;
      acc -= longint'(coef_shadow[pfcu_pkg::REG_BARRIER]) * well_term;
      acc -= longint'(coef_shadow[pfcu_pkg::REG_CROSS]) * cross_term;
      acc += longint'(coef_shadow[pfcu_pkg::REG_GRAD_X]) * lap_x;
      acc += longint'(coef_shadow[pfcu_pkg::REG_GRAD_Y]) * lap_y;
      acc += longint'(coef_shadow[pfcu_pkg::REG_GRAD_Z]) * lap_z;
      res = round_shift(acc, COEF_FRAC_BITS);
      r.saturated = 1'b0;
      if (res > 32767) begin
         res = 32767;
         r.saturated = 1'b1;
      end else if (res < -32768) begin
         res = -32768;
         r.saturated = 1'b1;
      end
      r.new_value = pfcu_pkg::value_type'(res);
      return r;
   endfunction

   function automatic cell_type make_cell(int c, int xm, int xp, int ym, int yp, int zm,
                                          int zp, int ga, int gb, int gc);
      cell_type site;
      site.center  = pfcu_pkg::value_type'(c);
      site.x_minus = pfcu_pkg::value_type'(xm);
      site.x_plus  = pfcu_pkg::value_type'(xp);
      site.y_minus = pfcu_pkg::value_type'(ym);
      site.y_plus  = pfcu_pkg::value_type'(yp);
      site.z_minus = pfcu_pkg::value_type'(zm);
      site.z_plus  = pfcu_pkg::value_type'(zp);
      site.grain_a = pfcu_pkg::value_type'(ga);
      site.grain_b = pfcu_pkg::value_type'(gb);
      site.grain_c = pfcu_pkg::value_type'(gc);
      return site;
   endfunction

   function automatic pfcu_pkg::value_type corner_value();
      case ($urandom_range(5, 0))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return 16'sh2000;
         4: return 16'shffff;
         default: return 16'sh0001;
      endcase
   endfunction

   // Neighbour close to the cell value, as in a smooth field
   function automatic pfcu_pkg::value_type near(pfcu_pkg::value_type base);
      return pfcu_pkg::value_type'(int'(base) + int'($urandom_range(2048, 0)) - 1024);
   endfunction

   function automatic pfcu_pkg::value_type grain_share();
      return ($urandom_range(1, 0) == 0) ? pfcu_pkg::value_type'(0) :
             pfcu_pkg::value_type'($urandom_range(8192, 0));
   endfunction

   function automatic cell_type random_cell();
      cell_type site;
      int style;
      style = $urandom_range(99, 0);
      if (style < 50) begin
         // physical range: values in [0, 1] with small excursions
         site.center  = pfcu_pkg::value_type'(int'($urandom_range(9400, 0)) - 600);
         site.x_minus = near(site.center);
         site.x_plus  = near(site.center);
         site.y_minus = near(site.center);
         site.y_plus  = near(site.center);
         site.z_minus = near(site.center);
         site.z_plus  = near(site.center);
         site.grain_a = grain_share();
         site.grain_b = grain_share();
         site.grain_c = grain_share();
      end else if (style < 75) begin
         site = make_cell($urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (style < 90) begin
         site = make_cell(corner_value(), corner_value(), corner_value(), corner_value(),
                          corner_value(), corner_value(), corner_value(), corner_value(),
                          corner_value(), corner_value());
      end else begin
         // single grain: other grains inactive
         site = make_cell($urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, 0, 0, 0);
      end
      return site;
   endfunction

   task automatic queue_cell(cell_type site);
      cell_queue.push_back(site);
      cells_sent++;
   endtask

   // APB transfer: setup cycle, then access until pready; reads are checked
   task automatic csr_access(bit wr, int idx, logic [pfcu_pkg::APB_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= pfcu_pkg::ADDR_W'(idx * 4);
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (wr && idx < pfcu_pkg::NUM_REGS) begin
         coef_shadow[idx] = pfcu_pkg::coef_type'(data[pfcu_pkg::COEF_W-1:0]);
      end else if (!wr && prdata[pfcu_pkg::COEF_W-1:0] !== coef_shadow[idx]) begin
         $error("coef[%0d]: expected %0d, got %0d", idx, coef_shadow[idx],
                $signed(prdata[pfcu_pkg::COEF_W-1:0]));
         mismatch_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_coef(int idx, pfcu_pkg::coef_type value);
      csr_access(1'b1, idx, {14'($urandom), value});
   endtask

   task automatic check_coefs();
      for (int i = 0; i < pfcu_pkg::NUM_REGS; i++) csr_access(1'b0, i, '0);
   endtask

   // Wait for every queued item to be taken and answered, then let the pipe empty
   task automatic wait_drained();
      int guard;
      guard = 0;
      while ((cells_taken != cells_sent || expected_updates.size() != 0) && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (12) @(posedge clock);
   endtask

   // Driver: takes items off the queue, random idle cycles with quiet stretches
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_updates.push_back(predict_update(cell_on_bus));
            cells_taken++;
         end
         if (!start || !busy) begin
            if (quiet_run > 0) begin
               quiet_run--;
               hold_off = 1'b0;
            end else begin
               if ($urandom_range(49, 0) == 0) quiet_run = $urandom_range(30, 8);
               hold_off = (idle_pct != 0) && ($urandom_range(99, 0) < idle_pct);
            end
            if (cell_queue.size() != 0 && !hold_off) begin
               cell_on_bus = cell_queue.pop_front();
               req_center        <= cell_on_bus.center;
               req_x_minus       <= cell_on_bus.x_minus;
               req_x_plus        <= cell_on_bus.x_plus;
               req_y_minus       <= cell_on_bus.y_minus;
               req_y_plus        <= cell_on_bus.y_plus;
               req_z_minus       <= cell_on_bus.z_minus;
               req_z_plus        <= cell_on_bus.z_plus;
               req_other_grain_a <= cell_on_bus.grain_a;
               req_other_grain_b <= cell_on_bus.grain_b;
               req_other_grain_c <= cell_on_bus.grain_c;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: each strobed result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_updates.size() == 0) begin
            $error("unexpected result: new_value %0d", rsp_new_value);
            mismatch_count++;
         end else begin
            next_update = expected_updates.pop_front();
            if (rsp_new_value !== next_update.new_value) begin
               $error("new_value: expected %0d, got %0d", next_update.new_value, rsp_new_value);
               mismatch_count++;
            end
            if (rsp_saturated !== next_update.saturated) begin
               $error("saturated: expected %0b, got %0b", next_update.saturated, rsp_saturated);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus: reset values first, then five coefficient settings
   initial begin
      pfcu_pkg::coef_type plan [pfcu_pkg::NUM_REGS];
      int phase_idle [LAST_PHASE+1];
      phase_idle = '{0, 84, 0, 33, 84, 0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_coefs();

      // directed cells under the reset coefficients
      queue_cell(make_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_cell(make_cell(8192, 8192, 8192, 8192, 8192, 8192, 8192, 0, 0, 0));
      queue_cell(make_cell(4096, 4096, 4096, 4096, 4096, 4096, 4096, 0, 0, 0));
      queue_cell(make_cell(4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 0, 0));
      queue_cell(make_cell(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                           32767, 32767, 32767));
      queue_cell(make_cell(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                           -32768, -32768, -32768));
      // steep gradients of both signs, the second clipped high
      queue_cell(make_cell(32767, -32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0));
      queue_cell(make_cell(-32768, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0));
      queue_cell(make_cell(-1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_cell(make_cell(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // strong cross-grain terms
      queue_cell(make_cell(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                           -32768, -32768, -32768));
      queue_cell(make_cell(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                           32767, 32767, 32767));
      queue_cell(make_cell(8192, 8192, 8192, 8192, 8192, 8192, 8192, 8192, 8192, 8192));
      // one axis at a time
      queue_cell(make_cell(4096, 8192, 0, 4096, 4096, 4096, 4096, 0, 0, 0));
      queue_cell(make_cell(4096, 4096, 4096, 0, 8192, 4096, 4096, 0, 0, 0));
      queue_cell(make_cell(4096, 4096, 4096, 4096, 4096, 8192, 0, 0, 0, 0));
      // interface between two grains, each grain field alone, then all three together
      queue_cell(make_cell(4096, 0, 8192, 0, 8192, 0, 8192, 4096, 0, 0));
      queue_cell(make_cell(2048, 0, 4096, 2048, 2048, 2048, 2048, 0, 6144, 0));
      queue_cell(make_cell(6144, 6144, 6144, 8192, 4096, 6144, 6144, 0, 0, 2048));
      queue_cell(make_cell(-8192, 0, 0, 0, 0, 0, 0, 8192, 8192, 8192));
      for (int n = 0; n < RANDOM_PER_PHASE; n++) queue_cell(random_cell());
      wait_drained();

      for (int phase = 1; phase <= LAST_PHASE; phase++) begin
         case (phase)
            1: plan = '{18'sh1ffff, -18'sh20000, 18'sh1ffff, -18'sh20000, 18'sh1ffff,
                        -18'sh20000};
            2: plan = '{-18'sh20000, 18'sh1ffff, -18'sh20000, 18'sh1ffff, -18'sh20000,
                        18'sh1ffff};
            3: begin
               for (int i = 0; i < pfcu_pkg::NUM_REGS; i++) begin
                  plan[i] = pfcu_pkg::coef_type'($urandom);
               end
            end
            4: begin
               for (int i = 0; i < pfcu_pkg::NUM_REGS; i++) begin
                  plan[i] = pfcu_pkg::coef_type'(int'($urandom_range(16383, 0)) - 8192);
               end
            end
            default: plan = '{'0, '0, '0, '0, '0, '0};
         endcase
         for (int i = 0; i < pfcu_pkg::NUM_REGS; i++) write_coef(i, plan[i]);
         // writes past the last register must be ignored
         write_coef(pfcu_pkg::NUM_REGS, pfcu_pkg::coef_type'($urandom));
         write_coef(pfcu_pkg::NUM_REGS + 1, pfcu_pkg::coef_type'($urandom));
         check_coefs();
         idle_pct = phase_idle[phase];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) queue_cell(random_cell());
         wait_drained();
      end

      if (expected_updates.size() != 0) begin
         $error("%0d results never arrived", expected_updates.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
